// ===== hw/rtl/spts_pkg.sv =====
// Shared constants, codes and types for the slotted page tuple store.
package spts_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int SLOT_BYTES   = 4;
  localparam int MAX_SLOTS    = 1024;

  localparam int PAGE_AW = 12;           // byte address within the page
  localparam int SLOT_AW = 10;           // slot directory index
  localparam int LEN_W   = 12;           // tuple length / offset field
  localparam int DIR_W   = 2 * LEN_W;    // {offset, length}

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_DELETE  = 2'd2;
  localparam logic [1:0] CMD_COMPACT = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO_LEN = 3'd1;
  localparam logic [2:0] ST_NO_SPACE = 3'd2;
  localparam logic [2:0] ST_BAD_SLOT = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_BEYOND   = 3'd5;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOOK  = 9'b000000010,
    S_RDB   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_COPY  = 9'b000010000,
    S_CWALK = 9'b000100000,
    S_CLEN  = 9'b001000000,
    S_CMOVE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

endpackage

// ===== hw/rtl/spts_ram.sv =====
// Generic simple dual-port RAM with registered read.
module spts_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/slotted_page_tuple_store_unit.sv =====
// Top level: slotted page store with page, scratch and slot directory RAMs.
// Inserts, failed requests and reads with no fetch go from S_LOOK to S_DONE; a read that fetches
// a byte passes through S_RDB first; the next request is taken the cycle after the result loads.
// Delete rescans the directory for the lowest live offset. Compact copies the page to scratch,
// then walks the slots and moves the bytes of each live tuple back (page copy, then byte moves).
// Reset clears control registers only; RAM contents are undefined until written.
module slotted_page_tuple_store_unit
  import spts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [SLOT_AW-1:0]   slot_number_i,
  input  logic [LEN_W-1:0]     record_length_i,
  input  logic [LEN_W-1:0]     byte_index_i,
  input  logic [7:0]           data_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [SLOT_AW-1:0]   assigned_slot_o,
  output logic [7:0]           data_out_o,
  output logic [LEN_W-1:0]     length_out_o,
  output logic [PAGE_AW:0]     free_bytes_o
);

  localparam logic [PAGE_AW:0] PageTop = (PAGE_AW + 1)'(PAGE_BYTES);

  state_e state_q, state_d;

  // latched request
  logic [1:0]         cmd_q;
  logic [SLOT_AW-1:0] slot_q;
  logic [LEN_W-1:0]   rlen_q, idx_q;
  logic [7:0]         din_q;

  // page bookkeeping
  logic [SLOT_AW:0]   slot_count_q, slot_count_d;
  logic [PAGE_AW:0]   dir_end_q, dir_end_d;
  logic [PAGE_AW-1:0] insert_base_q, insert_base_d;
  logic               insert_failed_q, insert_failed_d;
  logic [PAGE_AW:0]   ds_q, ds_d;          // tuple data start

  // per-request result
  logic [2:0]         res_status_q, res_status_d;
  logic [SLOT_AW-1:0] res_slot_q, res_slot_d;
  logic [7:0]         res_dout_q, res_dout_d;
  logic [LEN_W-1:0]   res_len_q, res_len_d;

  // sweep counters and the one-deep RAM pipeline
  logic [PAGE_AW:0]   cnt_q, cnt_d;
  logic [PAGE_AW:0]   min_q, min_d;
  logic [PAGE_AW:0]   pos_q, pos_d;
  logic [LEN_W-1:0]   mv_src_q, mv_src_d, mv_len_q, mv_len_d, mv_j_q, mv_j_d;
  logic               pipe_v_q, pipe_v_d;
  logic               pipe_ok_q, pipe_ok_d;
  logic [PAGE_AW-1:0] pipe_a_q, pipe_a_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_status_q, out_status_d;
  logic [SLOT_AW-1:0] out_slot_q, out_slot_d;
  logic [7:0]         out_dout_q, out_dout_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  logic [PAGE_AW:0]   out_free_q, out_free_d;

  // RAM ports
  logic               page_we, scr_we, dir_we;
  logic [PAGE_AW-1:0] page_waddr, page_raddr, scr_waddr, scr_raddr;
  logic [7:0]         page_wdata, page_rdata, scr_wdata, scr_rdata;
  logic [SLOT_AW-1:0] dir_waddr, dir_raddr;
  logic [DIR_W-1:0]   dir_wdata, dir_rdata;
  logic [LEN_W-1:0]   dir_off, dir_len;

  assign dir_off = dir_rdata[DIR_W-1:LEN_W];
  assign dir_len = dir_rdata[LEN_W-1:0];

  spts_ram #(.Width(8), .Depth(PAGE_BYTES)) u_page_ram (
    .clk_i, .we_i(page_we), .waddr_i(page_waddr), .wdata_i(page_wdata),
    .raddr_i(page_raddr), .rdata_o(page_rdata)
  );

  spts_ram #(.Width(8), .Depth(PAGE_BYTES)) u_scratch_ram (
    .clk_i, .we_i(scr_we), .waddr_i(scr_waddr), .wdata_i(scr_wdata),
    .raddr_i(scr_raddr), .rdata_o(scr_rdata)
  );

  spts_ram #(.Width(DIR_W), .Depth(MAX_SLOTS)) u_dir_ram (
    .clk_i, .we_i(dir_we), .waddr_i(dir_waddr), .wdata_i(dir_wdata),
    .raddr_i(dir_raddr), .rdata_o(dir_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);

  // scratch temporaries
  logic [PAGE_AW+1:0] need;
  logic [PAGE_AW:0]   ins_off, addr13, min_n, lenc, newpos, end_n;

  always_comb begin
    state_d         = state_q;
    slot_count_d    = slot_count_q;
    dir_end_d       = dir_end_q;
    insert_base_d   = insert_base_q;
    insert_failed_d = insert_failed_q;
    ds_d            = ds_q;
    res_status_d    = res_status_q;
    res_slot_d      = res_slot_q;
    res_dout_d      = res_dout_q;
    res_len_d       = res_len_q;
    cnt_d           = cnt_q;
    min_d           = min_q;
    pos_d           = pos_q;
    mv_src_d        = mv_src_q;
    mv_len_d        = mv_len_q;
    mv_j_d          = mv_j_q;
    pipe_v_d        = 1'b0;
    pipe_ok_d       = pipe_ok_q;
    pipe_a_d        = pipe_a_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_status_d    = out_status_q;
    out_slot_d      = out_slot_q;
    out_dout_d      = out_dout_q;
    out_len_d       = out_len_q;
    out_free_d      = out_free_q;

    page_we    = 1'b0;
    page_waddr = pipe_a_q;
    page_wdata = pipe_ok_q ? scr_rdata : 8'd0;
    page_raddr = cnt_q[PAGE_AW-1:0];
    scr_we     = 1'b0;
    scr_waddr  = pipe_a_q;
    scr_wdata  = page_rdata;
    scr_raddr  = pipe_a_q;
    dir_we     = 1'b0;
    dir_waddr  = slot_q;
    dir_wdata  = dir_rdata;
    dir_raddr  = cnt_q[SLOT_AW-1:0];

    need    = {1'b0, dir_end_q} + (PAGE_AW + 2)'(SLOT_BYTES) + {2'b0, rlen_q};
    ins_off = ds_q - {1'b0, rlen_q};
    addr13  = {1'b0, insert_base_q} + {1'b0, idx_q};
    min_n   = min_q;
    lenc    = ({1'b0, dir_len} > pos_q) ? pos_q : {1'b0, dir_len};
    newpos  = pos_q - lenc;
    end_n   = dir_end_q + (PAGE_AW + 1)'(SLOT_BYTES);

    case (state_q)
      S_IDLE: begin
        // start the directory lookup with the request itself
        dir_raddr = (cmd_i == CMD_INSERT) ? slot_count_q[SLOT_AW-1:0] - 1'b1 : slot_number_i;
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_dout_d   = '0;
          res_len_d    = '0;
          state_d      = S_LOOK;
        end
      end

      S_LOOK: begin
        state_d = S_DONE;
        case (cmd_q)
          CMD_INSERT: begin
            if (idx_q == '0) begin
              if (rlen_q == '0) begin
                res_status_d    = ST_ZERO_LEN;
                insert_failed_d = 1'b1;
              end else if (slot_count_q >= (SLOT_AW + 1)'(MAX_SLOTS) ||
                           need > {1'b0, ds_q}) begin
                res_status_d    = ST_NO_SPACE;
                insert_failed_d = 1'b1;
              end else begin
                // reserve the slot just below the current data start
                dir_we          = 1'b1;
                dir_waddr       = slot_count_q[SLOT_AW-1:0];
                dir_wdata       = {ins_off[PAGE_AW-1:0], rlen_q};
                res_slot_d      = slot_count_q[SLOT_AW-1:0];
                slot_count_d    = slot_count_q + 1'b1;
                dir_end_d       = end_n;
                insert_base_d   = ins_off[PAGE_AW-1:0];
                insert_failed_d = 1'b0;
                ds_d            = ins_off;
                page_we         = 1'b1;
                page_waddr      = ins_off[PAGE_AW-1:0];
                page_wdata      = din_q;
              end
            end else if (insert_failed_q) begin
              res_status_d = (rlen_q == '0) ? ST_ZERO_LEN : ST_NO_SPACE;
            end else if (slot_count_q == '0) begin
              res_status_d = ST_BAD_SLOT;
            end else if (dir_len == '0) begin
              res_status_d = ST_DELETED;
            end else if (idx_q >= dir_len) begin
              res_status_d = ST_BEYOND;
            end else begin
              res_slot_d = slot_count_q[SLOT_AW-1:0] - 1'b1;
              if (addr13 < PageTop) begin
                page_we    = 1'b1;
                page_waddr = addr13[PAGE_AW-1:0];
                page_wdata = din_q;
              end
            end
          end
          CMD_READ, CMD_DELETE: begin
            if ({1'b0, slot_q} >= slot_count_q) begin
              res_status_d = ST_BAD_SLOT;
            end else if (dir_len == '0) begin
              res_status_d = ST_DELETED;
            end else if (cmd_q == CMD_DELETE) begin
              dir_we    = 1'b1;
              dir_waddr = slot_q;
              dir_wdata = {dir_off, {LEN_W{1'b0}}};
              cnt_d     = '0;
              min_d     = PageTop;
              state_d   = S_SCAN;
            end else begin
              res_len_d = dir_len;
              addr13    = {1'b0, dir_off} + {1'b0, idx_q};
              if (idx_q >= dir_len) begin
                res_status_d = ST_BEYOND;
              end else if (addr13 < PageTop) begin
                page_raddr = addr13[PAGE_AW-1:0];
                state_d    = S_RDB;
              end
            end
          end
          CMD_COMPACT: begin
            cnt_d   = '0;
            pos_d   = PageTop;
            state_d = S_COPY;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_RDB: begin
        res_dout_d = page_rdata;
        state_d    = S_DONE;
      end

      S_SCAN: begin
        // lowest offset among live slots
        if (pipe_v_q && dir_len != '0 && {1'b0, dir_off} < min_q) begin
          min_n = {1'b0, dir_off};
        end
        min_d = min_n;
        if (cnt_q < {2'b0, slot_count_q}) begin
          dir_raddr = cnt_q[SLOT_AW-1:0];
          pipe_v_d  = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end else begin
          ds_d    = min_n;
          state_d = S_DONE;
        end
      end

      S_COPY: begin
        if (pipe_v_q) begin
          scr_we = 1'b1;
        end
        if (cnt_q < PageTop) begin
          page_raddr = cnt_q[PAGE_AW-1:0];
          pipe_v_d   = 1'b1;
          pipe_a_d   = cnt_q[PAGE_AW-1:0];
          cnt_d      = cnt_q + 1'b1;
        end else begin
          cnt_d   = '0;
          state_d = S_CWALK;
        end
      end

      S_CWALK: begin
        if (cnt_q == {2'b0, slot_count_q}) begin
          ds_d    = pos_q;
          state_d = S_DONE;
        end else begin
          dir_raddr = cnt_q[SLOT_AW-1:0];
          state_d   = S_CLEN;
        end
      end

      S_CLEN: begin
        if (dir_len == '0) begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_CWALK;
        end else begin
          pos_d     = newpos;
          dir_we    = 1'b1;
          dir_waddr = cnt_q[SLOT_AW-1:0];
          dir_wdata = {newpos[PAGE_AW-1:0], dir_len};
          mv_src_d  = dir_off;
          mv_len_d  = lenc[LEN_W-1:0];
          mv_j_d    = '0;
          // the open insert follows its slot
          if (cnt_q == {2'b0, slot_count_q} - 1'b1) begin
            insert_base_d = newpos[PAGE_AW-1:0];
          end
          state_d = S_CMOVE;
        end
      end

      S_CMOVE: begin
        if (pipe_v_q) begin
          page_we = 1'b1;
        end
        addr13 = {1'b0, mv_src_q} + {1'b0, mv_j_q};
        if (mv_j_q < mv_len_q) begin
          scr_raddr = addr13[PAGE_AW-1:0];
          pipe_v_d  = 1'b1;
          pipe_ok_d = addr13 < PageTop;
          pipe_a_d  = pos_q[PAGE_AW-1:0] + mv_j_q;
          mv_j_d    = mv_j_q + 1'b1;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_CWALK;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_dout_d   = res_dout_q;
          out_len_d    = res_len_q;
          out_free_d   = (end_n >= ds_q) ? '0 : ds_q - end_n;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      slot_count_q    <= '0;
      dir_end_q       <= (PAGE_AW + 1)'(HEADER_BYTES);
      insert_base_q   <= '0;
      insert_failed_q <= 1'b0;
      ds_q            <= PageTop;
      pipe_v_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      slot_count_q    <= slot_count_d;
      dir_end_q       <= dir_end_d;
      insert_base_q   <= insert_base_d;
      insert_failed_q <= insert_failed_d;
      ds_q            <= ds_d;
      pipe_v_q        <= pipe_v_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_number_i;
      rlen_q <= record_length_i;
      idx_q  <= byte_index_i;
      din_q  <= data_in_i;
    end
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_dout_q   <= res_dout_d;
    res_len_q    <= res_len_d;
    cnt_q        <= cnt_d;
    min_q        <= min_d;
    pos_q        <= pos_d;
    mv_src_q     <= mv_src_d;
    mv_len_q     <= mv_len_d;
    mv_j_q       <= mv_j_d;
    pipe_ok_q    <= pipe_ok_d;
    pipe_a_q     <= pipe_a_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_dout_q   <= out_dout_d;
    out_len_q    <= out_len_d;
    out_free_q   <= out_free_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign assigned_slot_o = out_slot_q;
  assign data_out_o      = out_dout_q;
  assign length_out_o    = out_len_q;
  assign free_bytes_o    = out_free_q;

endmodule

// ===== hw/rtl/spts_checker.sv =====
// Port-level checker for the slotted page store, bound to the top level.
module spts_checker
  import spts_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [2:0]          status_o,
  input logic [SLOT_AW-1:0]  assigned_slot_o,
  input logic [7:0]          data_out_o,
  input logic [LEN_W-1:0]    length_out_o,
  input logic [PAGE_AW:0]    free_bytes_o
);

  // a held result stays valid and keeps its status and free-space count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(free_bytes_o))
    else $error("held result changed");

  // a failed request never reports a slot or a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> assigned_slot_o == '0 && data_out_o == '0)
    else $error("failed request carries slot or data");

  // length is only shown for ok or beyond-length reads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK && status_o != ST_BEYOND |-> length_out_o == '0)
    else $error("length on failed request");

  // free space never exceeds the page and the status stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> free_bytes_o <= (PAGE_AW + 1)'(PAGE_BYTES) && status_o <= ST_BEYOND)
    else $error("free space or status out of range");

  // one request at a time: after an accept the input side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

endmodule

bind slotted_page_tuple_store_unit spts_checker u_spts_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .assigned_slot_o, .data_out_o, .length_out_o, .free_bytes_o
);
